// ----- rtl/core/iws_pkg.sv -----
// ----------------------------------------------------------------------------
// iws_pkg
// Shared types and constants of the identifier word splitter.
// ----------------------------------------------------------------------------
package iws_pkg;

	localparam logic [7:0] UNDERSCORE_CODE = 8'h5F;
	localparam logic [7:0] CAP_FIRST       = 8'h41;
	localparam logic [7:0] CAP_LAST        = 8'h5A;
	localparam logic [7:0] SMALL_FIRST     = 8'h61;
	localparam logic [7:0] SMALL_LAST      = 8'h7A;

	localparam int unsigned OUT_DEPTH = 2;
	localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [7:0] word_start;
		logic [8:0] word_length;
		logic       name_done;
		logic       too_long;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		result_t          first;
		result_t          second;
	} push_t;

endpackage

// ----- rtl/core/iws_char_if.sv -----
// ----------------------------------------------------------------------------
// iws_char_if
// Character channel: one identifier character per item.
// ----------------------------------------------------------------------------
interface iws_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/core/iws_word_if.sv -----
// ----------------------------------------------------------------------------
// iws_word_if
// Word channel: one word span or closing result per item.
// ----------------------------------------------------------------------------
interface iws_word_if;
	logic       valid;
	logic       ready;
	logic [7:0] word_start;
	logic [8:0] word_length;
	logic       name_done;
	logic       too_long;

	modport source (output valid, output word_start, output word_length,
		output name_done, output too_long, input ready);
	modport sink (input valid, input word_start, input word_length,
		input name_done, input too_long, output ready);
endinterface

// ----- rtl/core/iws_cfg_if.sv -----
// ----------------------------------------------------------------------------
// iws_cfg_if
// Configuration write channel carrying the split mode.
// ----------------------------------------------------------------------------
interface iws_cfg_if;
	logic valid;
	logic ready;
	logic split_mode;

	modport source (output valid, output split_mode, input ready);
	modport sink (input valid, input split_mode, output ready);
endinterface

// ----- rtl/core/iws_step.sv -----
// ----------------------------------------------------------------------------
// iws_step
// Next-state and result logic for one character of an identifier.
// ----------------------------------------------------------------------------
module iws_step #(
	parameter int unsigned MAX_NAME_LEN = 256,
	parameter int unsigned PW = $clog2(MAX_NAME_LEN + 1)
) (
	input  logic [7:0]    char_code,
	input  logic          last_char,
	input  logic          split_mode,
	input  logic [PW-1:0] pos,
	input  logic [PW-1:0] wb,
	input  logic [PW-1:0] we,
	input  logic          run,
	input  logic          ovf,
	output logic [PW-1:0] pos_n,
	output logic [PW-1:0] wb_n,
	output logic [PW-1:0] we_n,
	output logic          run_n,
	output logic          ovf_n,
	output iws_pkg::push_t push
);

	localparam logic [PW-1:0] MAX_POS = PW'(MAX_NAME_LEN);

	logic          is_cap;
	logic          is_small;
	logic          is_und;
	logic [PW-1:0] b;
	logic [PW-1:0] e;
	logic          r;
	logic [PW-1:0] i_plus;
	logic          w_valid;
	logic [PW-1:0] w_start;
	logic [PW-1:0] w_len;
	iws_pkg::result_t w_res;
	iws_pkg::result_t c_res;

	assign is_cap   = (char_code >= iws_pkg::CAP_FIRST) && (char_code <= iws_pkg::CAP_LAST);
	assign is_small = (char_code >= iws_pkg::SMALL_FIRST) && (char_code <= iws_pkg::SMALL_LAST);
	assign is_und   = (char_code == iws_pkg::UNDERSCORE_CODE);
	assign i_plus   = pos + PW'(1);

	always_comb begin
		b       = wb;
		e       = we;
		r       = run;
		w_valid = 1'b0;
		w_start = '0;
		w_len   = '0;
		pos_n   = pos;
		ovf_n   = ovf;
		if (pos >= MAX_POS) begin
			ovf_n = 1'b1;
		end else begin
			if (pos == '0) begin
				b = '0;
				e = PW'(1);
				r = split_mode ? is_cap : is_und;
			end
			if (!split_mode) begin
				if (is_und) begin
					if ((e > b) && !r) begin
						w_valid = 1'b1;
						w_start = b;
						w_len   = e - b;
					end
					b = i_plus;
					e = i_plus;
					r = 1'b1;
				end else if (r) begin
					b = pos;
					e = i_plus;
					r = 1'b0;
				end else begin
					e = i_plus;
				end
			end else begin
				if (is_cap) begin
					if (r) begin
						e = i_plus;
					end else begin
						if (e > b) begin
							w_valid = 1'b1;
							w_start = b;
							w_len   = e - b;
						end
						b = pos;
						e = i_plus;
						r = 1'b1;
					end
				end else if (is_small) begin
					if (r && (e > b) && ((e - b) != PW'(1))) begin
						w_valid = 1'b1;
						w_start = b;
						w_len   = e - b - PW'(1);
						b       = e - PW'(1);
					end
					e = i_plus;
					r = 1'b0;
				end
			end
			pos_n = i_plus;
		end

		w_res.word_start  = 8'(w_start);
		w_res.word_length = 9'(w_len);
		w_res.name_done   = 1'b0;
		w_res.too_long    = ovf_n;

		if (e > b) begin
			c_res.word_start  = 8'(b);
			c_res.word_length = 9'(e - b);
		end else begin
			c_res.word_start  = '0;
			c_res.word_length = '0;
		end
		c_res.name_done = 1'b1;
		c_res.too_long  = ovf_n;

		wb_n  = b;
		we_n  = e;
		run_n = r;
		if (last_char) begin
			pos_n = '0;
			wb_n  = '0;
			we_n  = '0;
			run_n = 1'b0;
			ovf_n = 1'b0;
		end

		push.count  = iws_pkg::CNT_W'(w_valid) + iws_pkg::CNT_W'(last_char);
		push.first  = w_valid ? w_res : c_res;
		push.second = c_res;
	end

endmodule

// ----- rtl/core/iws_out_q.sv -----
// ----------------------------------------------------------------------------
// iws_out_q
// Two-entry result queue that feeds the word channel.
// ----------------------------------------------------------------------------
module iws_out_q (
	input  logic                        clk,
	input  logic                        arst_n,
	input  iws_pkg::push_t              push,
	input  logic                        out_ready,
	output logic                        out_valid,
	output iws_pkg::result_t            head,
	output logic [iws_pkg::CNT_W-1:0]   cnt
);

	iws_pkg::result_t            q0_q;
	iws_pkg::result_t            q1_q;
	logic [iws_pkg::CNT_W-1:0]   cnt_q;
	iws_pkg::result_t            q0_n;
	iws_pkg::result_t            q1_n;
	logic [iws_pkg::CNT_W-1:0]   cnt_p;
	logic [iws_pkg::CNT_W-1:0]   cnt_n;
	logic                        pop;

	assign out_valid = (cnt_q != '0);
	assign head      = q0_q;
	assign cnt       = cnt_q;
	assign pop       = out_valid && out_ready;

	always_comb begin
		q0_n  = q0_q;
		q1_n  = q1_q;
		cnt_p = cnt_q;
		if (pop) begin
			q0_n  = q1_q;
			cnt_p = cnt_q - iws_pkg::CNT_W'(1);
		end
		if (push.count != '0) begin
			if (cnt_p == '0) begin
				q0_n = push.first;
			end else begin
				q1_n = push.first;
			end
		end
		if (push.count == iws_pkg::CNT_W'(2)) begin
			q1_n = push.second;
		end
		cnt_n = cnt_p + push.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		q0_q <= q0_n;
		q1_q <= q1_n;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= iws_pkg::CNT_W'(iws_pkg::OUT_DEPTH))
		else $error("result queue count out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != '0 |->
		({1'b0, cnt_q} + {1'b0, push.count}) <= (iws_pkg::CNT_W + 1)'(iws_pkg::OUT_DEPTH))
		else $error("result queue pushed beyond its depth");

	a_pop_shift: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cnt_q == iws_pkg::CNT_W'(2) && push.count == '0 |=>
		cnt_q == iws_pkg::CNT_W'(1) && head == $past(q1_q))
		else $error("result queue lost its second entry on a pop");

endmodule

// ----- rtl/core/identifier_word_splitter_core.sv -----
// ----------------------------------------------------------------------------
// identifier_word_splitter_core
// Splits an identifier, streamed one character per item, into word spans.
// ----------------------------------------------------------------------------
// The chars channel takes one character per item, with last_char set on the
// final character of an identifier. The words channel returns the start and
// length of each word as soon as it is known, and one closing item with
// name_done set per identifier. The cfg channel writes split_mode (0 splits
// on underscores, 1 at letter case changes); it is always ready. The user
// is to write it only while the block holds no work; the block itself does
// not enforce this. An accepted character is held in an input register,
// then its results enter a two-entry result queue whose head is offered
// on the words channel. One character is accepted per cycle while the words
// side keeps up and the result queue has room for its results. A character
// that ends a word and the identifier at once yields two items, offered one
// after the other. Queue room is judged before the current pop, so a
// character whose results would overfill the queue waits in the input
// register while the queue drains.
// Reset clears the span state, the result queue and split_mode. When the receiver
// stalls, the queue fills and the input register holds its character, and
// chars.ready falls until space frees up; nothing is lost.
// ----------------------------------------------------------------------------
module identifier_word_splitter_core #(
	parameter int unsigned MAX_NAME_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	iws_cfg_if.sink     cfg,
	iws_char_if.sink    chars,
	iws_word_if.source  words
);

	localparam int unsigned PW = $clog2(MAX_NAME_LEN + 1);

	logic                      mode_q;
	logic                      s1_v;
	logic [7:0]                s1_char;
	logic                      s1_last;
	logic [PW-1:0]             pos_q;
	logic [PW-1:0]             wb_q;
	logic [PW-1:0]             we_q;
	logic                      run_q;
	logic                      ovf_q;
	logic [PW-1:0]             pos_n;
	logic [PW-1:0]             wb_n;
	logic [PW-1:0]             we_n;
	logic                      run_n;
	logic                      ovf_n;
	iws_pkg::push_t            step_push;
	iws_pkg::push_t            push;
	iws_pkg::result_t          head;
	logic [iws_pkg::CNT_W-1:0] cnt;
	logic                      fire;
	logic                      take;

	assign cfg.ready = 1'b1;

	assign fire = s1_v &&
		(({1'b0, cnt} + {1'b0, step_push.count}) <= (iws_pkg::CNT_W + 1)'(iws_pkg::OUT_DEPTH));
	assign chars.ready = !s1_v || fire;
	assign take        = chars.valid && chars.ready;

	always_comb begin
		push       = step_push;
		push.count = fire ? step_push.count : '0;
	end

	iws_step #(
		.MAX_NAME_LEN (MAX_NAME_LEN),
		.PW           (PW)
	) u_step (
		.char_code  (s1_char),
		.last_char  (s1_last),
		.split_mode (mode_q),
		.pos        (pos_q),
		.wb         (wb_q),
		.we         (we_q),
		.run        (run_q),
		.ovf        (ovf_q),
		.pos_n      (pos_n),
		.wb_n       (wb_n),
		.we_n       (we_n),
		.run_n      (run_n),
		.ovf_n      (ovf_n),
		.push       (step_push)
	);

	iws_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_ready (words.ready),
		.out_valid (words.valid),
		.head      (head),
		.cnt       (cnt)
	);

	assign words.word_start  = head.word_start;
	assign words.word_length = head.word_length;
	assign words.name_done   = head.name_done;
	assign words.too_long    = head.too_long;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			s1_v   <= 1'b0;
			pos_q  <= '0;
			wb_q   <= '0;
			we_q   <= '0;
			run_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mode_q <= cfg.split_mode;
			end
			if (take) begin
				s1_v <= 1'b1;
			end else if (fire) begin
				s1_v <= 1'b0;
			end
			if (fire) begin
				pos_q <= pos_n;
				wb_q  <= wb_n;
				we_q  <= we_n;
				run_q <= run_n;
				ovf_q <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_char <= chars.char_code;
			s1_last <= chars.last_char;
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_NAME_LEN))
		else $error("character position passed the maximum length");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && s1_last |=> pos_q == '0 && !ovf_q && !run_q)
		else $error("span state not cleared after a closing result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && !fire |=> s1_v && $stable(s1_char) && $stable(s1_last))
		else $error("held character changed while waiting for queue space");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the identifier word splitter core.
// ----------------------------------------------------------------------------
// Identifiers are streamed one character per item on the chars channel. A
// directed table covers the special cases in both split modes, including a
// mode change in the middle of a name. Random names follow, with two names
// that run past the length limit. The bench keeps its own model of the
// splitter, and every word item that comes back is compared with the oldest
// expected one. Both channels idle at random, and at one point the words
// side holds off long enough to stall the chars side.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_NAME    = 256;
	localparam int          ITEM_TARGET = 850;
	localparam int          CALM_ITEMS  = 100;
	localparam int          HOLD_CYCLES = 64;
	localparam int          SETTLE      = 6;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          PRINT_LIMIT = 100;
	localparam int          DIRECTED_N  = 24;

	localparam iws_pkg::result_t NO_WORD = '0;

	typedef struct packed {
		logic             mode;
		logic [7:0]       code;
		logic             is_last;
		logic             typed;
		logic [1:0]       n_typed;
		iws_pkg::result_t w0;
		iws_pkg::result_t w1;
	} row_t;

	localparam row_t DIRECTED_ROWS [DIRECTED_N] = '{
		'{1'b0, "a", 1'b1, 1'b1, 2'd1, '{8'd0, 9'd1, 1'b1, 1'b0}, NO_WORD},
		'{1'b0, iws_pkg::UNDERSCORE_CODE, 1'b1, 1'b1, 2'd1, '{8'd0, 9'd0, 1'b1, 1'b0},
			NO_WORD},
		'{1'b0, "a", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b0, "b", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b0, iws_pkg::UNDERSCORE_CODE, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b0, iws_pkg::UNDERSCORE_CODE, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b0, "c", 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b0, 8'hFF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b0, 8'h00, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "a", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "B", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "c", 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "A", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "B", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "C", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "d", 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "x", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "9", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "Y", 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, "5", 1'b1, 1'b1, 2'd1, '{8'd0, 9'd1, 1'b1, 1'b0}, NO_WORD},
		'{1'b1, "q", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b1, iws_pkg::UNDERSCORE_CODE, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b0, "r", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
		'{1'b0, iws_pkg::UNDERSCORE_CODE, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD}
	};

	logic clk;
	logic arst_n;

	iws_cfg_if  cfg_ch ();
	iws_char_if chars_ch ();
	iws_word_if words_ch ();

	identifier_word_splitter_core #(
		.MAX_NAME_LEN(MAX_NAME)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.chars (chars_ch),
		.words (words_ch)
	);

	logic       split_by_case = 1'b0;
	logic [8:0] seen_chars    = '0;
	logic [8:0] span_lo       = '0;
	logic [8:0] span_hi       = '0;
	logic       in_run        = 1'b0;
	logic       chars_dropped = 1'b0;

	iws_pkg::result_t predicted [2];
	int               n_predicted = 0;
	iws_pkg::result_t words_due [$];

	int items_sent  = 0;
	int error_total = 0;
	bit hold_words  = 1'b0;
	bit calm        = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_error(input string what);
		error_total++;
		if (error_total <= PRINT_LIMIT) begin
			$display("ERROR at %0t: %s", $realtime, what);
		end
	endtask

	function automatic void emit_word(input logic [8:0] lo, input logic [8:0] len,
		input logic done);
		predicted[n_predicted] = '{lo[7:0], len, done, chars_dropped};
		n_predicted++;
	endfunction

	function automatic void advance_splitter(input logic [7:0] c, input logic is_last);
		logic       cap;
		logic       sml;
		logic       usc;
		logic [8:0] i;
		n_predicted = 0;
		cap = (c >= iws_pkg::CAP_FIRST) && (c <= iws_pkg::CAP_LAST);
		sml = (c >= iws_pkg::SMALL_FIRST) && (c <= iws_pkg::SMALL_LAST);
		usc = (c == iws_pkg::UNDERSCORE_CODE);
		if (seen_chars >= MAX_NAME) begin
			chars_dropped = 1'b1;
		end else begin
			i = seen_chars;
			if (i == 0) begin
				span_lo = '0;
				span_hi = 9'd1;
				in_run = split_by_case ? cap : usc;
			end
			if (!split_by_case) begin
				if (usc) begin
					if (span_hi > span_lo && !in_run) begin
						emit_word(span_lo, span_hi - span_lo, 1'b0);
					end
					span_lo = i + 9'd1;
					span_hi = i + 9'd1;
					in_run = 1'b1;
				end else if (in_run) begin
					span_lo = i;
					span_hi = i + 9'd1;
					in_run = 1'b0;
				end else begin
					span_hi = i + 9'd1;
				end
			end else if (cap) begin
				if (in_run) begin
					span_hi = i + 9'd1;
				end else begin
					if (span_hi > span_lo) begin
						emit_word(span_lo, span_hi - span_lo, 1'b0);
					end
					span_lo = i;
					span_hi = i + 9'd1;
					in_run = 1'b1;
				end
			end else if (sml) begin
				if (in_run && span_hi > span_lo + 9'd1) begin
					emit_word(span_lo, span_hi - span_lo - 9'd1, 1'b0);
					span_lo = span_hi - 9'd1;
				end
				span_hi = i + 9'd1;
				in_run = 1'b0;
			end
			seen_chars = i + 9'd1;
		end
		if (is_last) begin
			if (span_hi > span_lo) begin
				emit_word(span_lo, span_hi - span_lo, 1'b1);
			end else begin
				emit_word('0, '0, 1'b1);
			end
			seen_chars = '0;
			span_lo = '0;
			span_hi = '0;
			in_run = 1'b0;
			chars_dropped = 1'b0;
		end
	endfunction

	function automatic logic [7:0] pick_char(input logic by_case);
		int unsigned r;
		logic [7:0]  c;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			c = 8'($urandom_range(0, 255));
		end else if (r < 18) begin
			c = 8'($urandom_range(8'h30, 8'h39));
		end else if (r < (by_case ? 28 : 45)) begin
			c = iws_pkg::UNDERSCORE_CODE;
		end else if (r < (by_case ? 64 : 60)) begin
			c = 8'($urandom_range(iws_pkg::CAP_FIRST, iws_pkg::CAP_LAST));
		end else begin
			c = 8'($urandom_range(iws_pkg::SMALL_FIRST, iws_pkg::SMALL_LAST));
		end
		return c;
	endfunction

	task automatic put_char(input logic [7:0] c, input logic is_last, input logic typed,
		input logic [1:0] n_typed, input iws_pkg::result_t t0, input iws_pkg::result_t t1);
		int k;
		chars_ch.valid <= 1'b1;
		chars_ch.char_code <= c;
		chars_ch.last_char <= is_last;
		do @(posedge clk); while (chars_ch.ready !== 1'b1);
		advance_splitter(c, is_last);
		items_sent++;
		if (typed) begin
			if (n_typed > 0) words_due.insert(words_due.size(), t0);
			if (n_typed > 1) words_due.insert(words_due.size(), t1);
		end else begin
			for (k = 0; k < n_predicted; k++) words_due.insert(words_due.size(), predicted[k]);
		end
	endtask

	task automatic sender_gap();
		if (!calm && $urandom_range(0, 7) == 0) begin
			chars_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic set_mode(input logic m);
		chars_ch.valid <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.split_mode <= m;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		split_by_case = m;
	endtask

	task automatic check_word();
		iws_pkg::result_t got;
		iws_pkg::result_t want;
		got.word_start = words_ch.word_start;
		got.word_length = words_ch.word_length;
		got.name_done = words_ch.name_done;
		got.too_long = words_ch.too_long;
		if (words_due.size() == 0) begin
			flag_error($sformatf("unexpected word start %0d length %0d done %b long %b",
				got.word_start, got.word_length, got.name_done, got.too_long));
		end else begin
			want = words_due.pop_front();
			if (got.word_start !== want.word_start)
				flag_error($sformatf("word_start %0d, expected %0d",
					got.word_start, want.word_start));
			if (got.word_length !== want.word_length)
				flag_error($sformatf("word_length %0d, expected %0d",
					got.word_length, want.word_length));
			if (got.name_done !== want.name_done)
				flag_error($sformatf("name_done %b, expected %b",
					got.name_done, want.name_done));
			if (got.too_long !== want.too_long)
				flag_error($sformatf("too_long %b, expected %b",
					got.too_long, want.too_long));
		end
	endtask

	initial begin
		int quiet;
		quiet = 0;
		words_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (words_ch.valid === 1'b1 && words_ch.ready === 1'b1) check_word();
			if (hold_words) begin
				quiet = HOLD_CYCLES;
				hold_words = 1'b0;
			end else if (quiet == 0 && !calm && $urandom_range(0, 7) == 0) begin
				quiet = $urandom_range(1, 6);
			end
			if (quiet > 0) begin
				words_ch.ready <= 1'b0;
				quiet--;
			end else begin
				words_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int         r;
		int         names;
		int         len;
		int         k;
		logic [7:0] c;
		arst_n <= 1'b0;
		chars_ch.valid <= 1'b0;
		chars_ch.char_code <= '0;
		chars_ch.last_char <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.split_mode <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < DIRECTED_N; r++) begin
			if (DIRECTED_ROWS[r].mode != split_by_case) set_mode(DIRECTED_ROWS[r].mode);
			sender_gap();
			put_char(DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].is_last, DIRECTED_ROWS[r].typed,
				DIRECTED_ROWS[r].n_typed, DIRECTED_ROWS[r].w0, DIRECTED_ROWS[r].w1);
		end

		names = 0;
		while (items_sent < ITEM_TARGET) begin
			if (names % 8 == 0) set_mode(~split_by_case);
			if (names == 3 || names == 11) begin
				len = $urandom_range(MAX_NAME + 1, MAX_NAME + 6);
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(13, 40);
			end else begin
				len = $urandom_range(1, 12);
			end
			if (names == 6) hold_words = 1'b1;
			if (names == 30) begin
				chars_ch.valid <= 1'b0;
				while (words_due.size() != 0) @(posedge clk);
			end
			for (k = 0; k < len; k++) begin
				calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
				sender_gap();
				if (names == 11) begin
					c = 8'($urandom_range(iws_pkg::SMALL_FIRST, iws_pkg::SMALL_LAST));
				end else begin
					c = pick_char(split_by_case);
				end
				put_char(c, k == len - 1, 1'b0, 2'd0, NO_WORD, NO_WORD);
			end
			names++;
		end

		chars_ch.valid <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (error_total == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
